>>> hdl/igdng_pkg.sv
// Shared types, constants and helpers for the input gain / DC blocker / noise gate block.
// Used by igdng_seq, input_gain_dc_block_noise_gate and igdng_checker; depends on nothing.
package igdng_pkg;

    // Formats
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int SW          = SAMPLE_BITS;          // sample
    localparam int XW          = SAMPLE_BITS + 1;      // saturated filter / gained value
    localparam int DW          = SAMPLE_BITS + 3;      // filter difference, signed
    localparam int CW          = COEF_BITS + 1;        // coefficient register
    localparam int BW          = (CW > XW) ? CW : XW;  // multiplier operand B
    localparam int PW          = DW + BW;              // product
    localparam int GAIN_FRAC   = SAMPLE_BITS - 4;
    localparam int GATE_FRAC   = SAMPLE_BITS - 1;
    localparam int MW          = PW - GAIN_FRAC + 1;   // rounded magnitude
    localparam int VW          = MW + 1;               // rounded signed value
    localparam int YW          = SAMPLE_BITS + 2;      // gated sample before output clip
    localparam int EW          = 63;                   // energy meter
    localparam int ESW         = EW + 1;               // energy sum
    localparam int THR_W       = SAMPLE_BITS - 1;

    localparam logic [CW-1:0]    COEF_ONE     = CW'(1) << COEF_BITS;
    localparam logic [CW-1:0]    K_GAIN_STEP  = CW'(((64'd2 << COEF_BITS) + 64'd50) / 64'd100);
    localparam logic [CW-1:0]    K_ENV_ATTACK = CW'(((64'd55 << COEF_BITS) + 64'd50) / 64'd100);
    localparam logic [SW-1:0]    GATE_ONE     = SW'(1) << GATE_FRAC;
    localparam logic [THR_W-1:0] PEAK_MAX     = '1;
    localparam logic [SW-1:0]    ENV_MAX      = '1;
    localparam logic [EW-1:0]    ENERGY_MAX   = '1;

    // Register reset values
    localparam logic [CW-1:0] DC_COEF_RST     = CW'(16737781);
    localparam logic [CW-1:0] BRIGHT_COEF_RST = CW'(13296183);
    localparam logic [CW-1:0] ENVREL_COEF_RST = CW'(139231);
    localparam logic [CW-1:0] ATT_COEF_RST    = CW'(288750);
    localparam logic [CW-1:0] REL_COEF_RST    = CW'(43634);

    // Register indexes
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] CFG_GATE_THR    = 3'd0;
    localparam logic [CFG_W-1:0] CFG_DC_COEF     = 3'd1;
    localparam logic [CFG_W-1:0] CFG_BRIGHT_COEF = 3'd2;
    localparam logic [CFG_W-1:0] CFG_ENVREL_COEF = 3'd3;
    localparam logic [CFG_W-1:0] CFG_ATT_COEF    = 3'd4;
    localparam logic [CFG_W-1:0] CFG_REL_COEF    = 3'd5;

    // Microcode fields
    localparam int PREP_W = 4;
    localparam logic [PREP_W-1:0] PREP_NONE   = 4'd0;
    localparam logic [PREP_W-1:0] PREP_GAIN   = 4'd1;
    localparam logic [PREP_W-1:0] PREP_BRIGHT = 4'd2;
    localparam logic [PREP_W-1:0] PREP_RAWSQ  = 4'd3;
    localparam logic [PREP_W-1:0] PREP_X      = 4'd4;
    localparam logic [PREP_W-1:0] PREP_BHSQ   = 4'd5;
    localparam logic [PREP_W-1:0] PREP_DC     = 4'd6;
    localparam logic [PREP_W-1:0] PREP_ENV    = 4'd7;
    localparam logic [PREP_W-1:0] PREP_GATE   = 4'd8;
    localparam logic [PREP_W-1:0] PREP_G2     = 4'd9;
    localparam logic [PREP_W-1:0] PREP_Y      = 4'd10;

    localparam int WB_W = 4;
    localparam logic [WB_W-1:0] WB_NONE   = 4'd0;
    localparam logic [WB_W-1:0] WB_GAIN   = 4'd1;
    localparam logic [WB_W-1:0] WB_BRIGHT = 4'd2;
    localparam logic [WB_W-1:0] WB_EACC   = 4'd3;
    localparam logic [WB_W-1:0] WB_X      = 4'd4;
    localparam logic [WB_W-1:0] WB_HACC   = 4'd5;
    localparam logic [WB_W-1:0] WB_DC     = 4'd6;
    localparam logic [WB_W-1:0] WB_ENV    = 4'd7;
    localparam logic [WB_W-1:0] WB_GATE   = 4'd8;
    localparam logic [WB_W-1:0] WB_G2     = 4'd9;
    localparam logic [WB_W-1:0] WB_Y      = 4'd10;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_PEAK   = 3'd1;
    localparam logic [OP_W-1:0] OP_AV     = 3'd2;
    localparam logic [OP_W-1:0] OP_DET    = 3'd3;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd4;

    localparam logic JMP_NONE     = 1'b0;
    localparam logic JMP_GATE_OFF = 1'b1;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_FINISH = 5'd23;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic [SW-1:0]        gain_target;
        logic                 clear_meters;
        logic                 last_in_block;
    } t_in;

    typedef struct packed {
        logic signed [SW-1:0] out_sample;
        logic                 gate_open;
        logic [THR_W-1:0]     peak_in;
        logic [EW-1:0]        energy_all;
        logic [EW-1:0]        energy_high;
    } t_out;

    typedef struct packed {
        logic [PREP_W-1:0] prep;
        logic [WB_W-1:0]   wb;
        logic [OP_W-1:0]   op;
        logic              jmp;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic gate_off;
        logic out_stall;
    } t_seq_in;

    localparam t_ctrl CW_IDLE = '{prep: PREP_NONE, wb: WB_NONE, op: OP_NONE,
                                  jmp: JMP_NONE, target: '0};

    function automatic logic [CW-1:0] coef_in(input logic [CW-1:0] v);
        coef_in = (v > COEF_ONE) ? COEF_ONE : v;
    endfunction

    function automatic logic signed [XW-1:0] sat_x(input logic signed [VW-1:0] v);
        if (v[VW-1:XW-1] == '0 || v[VW-1:XW-1] == '1) begin
            sat_x = v[XW-1:0];
        end else begin
            sat_x = v[VW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SW-1:0] sat_s(input logic signed [YW-1:0] v);
        if (v[YW-1:SW-1] == '0 || v[YW-1:SW-1] == '1) begin
            sat_s = v[SW-1:0];
        end else begin
            sat_s = v[YW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

endpackage

>>> hdl/igdng_seq.sv
// Microcode sequencer: step counter, program ROM and the conditional jump.
// Depends on igdng_pkg for the control word and status types.
module igdng_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  igdng_pkg::t_seq_in i_stat,
    output igdng_pkg::t_ctrl  o_ctrl,
    output logic              o_busy
);

    logic                            r_busy;
    logic [igdng_pkg::STEP_W-1:0]    r_step;
    igdng_pkg::t_ctrl                word;
    logic                            stall;

    function automatic igdng_pkg::t_ctrl uword(
        input logic [igdng_pkg::PREP_W-1:0] prep,
        input logic [igdng_pkg::WB_W-1:0]   wb,
        input logic [igdng_pkg::OP_W-1:0]   op
    );
        igdng_pkg::t_ctrl w;
        w        = igdng_pkg::CW_IDLE;
        w.prep   = prep;
        w.wb     = wb;
        w.op     = op;
        uword    = w;
    endfunction

    // Program: prep loads the multiplier operands into r_opa / r_opb, r_prod registers their
    // product, and a later wb step rounds and stores it.
    function automatic igdng_pkg::t_ctrl rom(input logic [igdng_pkg::STEP_W-1:0] step);
        igdng_pkg::t_ctrl w;
        case (step)
            5'd0:  w = uword(igdng_pkg::PREP_GAIN,   igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd1:  w = uword(igdng_pkg::PREP_BRIGHT, igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd2:  w = uword(igdng_pkg::PREP_RAWSQ,  igdng_pkg::WB_GAIN,   igdng_pkg::OP_NONE);
            5'd3:  w = uword(igdng_pkg::PREP_X,      igdng_pkg::WB_BRIGHT, igdng_pkg::OP_NONE);
            5'd4:  w = uword(igdng_pkg::PREP_BHSQ,   igdng_pkg::WB_EACC,   igdng_pkg::OP_NONE);
            5'd5:  w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_X,      igdng_pkg::OP_NONE);
            5'd6:  w = uword(igdng_pkg::PREP_DC,     igdng_pkg::WB_HACC,   igdng_pkg::OP_PEAK);
            5'd7:  w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd8:  w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_DC,     igdng_pkg::OP_NONE);
            5'd9:  w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_NONE,   igdng_pkg::OP_AV);
            5'd10: w = uword(igdng_pkg::PREP_ENV,    igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd11: w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd12: begin
                w        = uword(igdng_pkg::PREP_NONE, igdng_pkg::WB_ENV, igdng_pkg::OP_NONE);
                w.jmp    = igdng_pkg::JMP_GATE_OFF;
                w.target = igdng_pkg::STEP_FINISH;
            end
            5'd13: w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_NONE,   igdng_pkg::OP_DET);
            5'd14: w = uword(igdng_pkg::PREP_GATE,   igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd15: w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd16: w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_GATE,   igdng_pkg::OP_NONE);
            5'd17: w = uword(igdng_pkg::PREP_G2,     igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd18: w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd19: w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_G2,     igdng_pkg::OP_NONE);
            5'd20: w = uword(igdng_pkg::PREP_Y,      igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd21: w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_NONE,   igdng_pkg::OP_NONE);
            5'd22: w = uword(igdng_pkg::PREP_NONE,   igdng_pkg::WB_Y,      igdng_pkg::OP_NONE);
            default: w = uword(igdng_pkg::PREP_NONE, igdng_pkg::WB_NONE,   igdng_pkg::OP_FINISH);
        endcase
        rom = w;
    endfunction

    always_comb begin
        word   = rom(r_step);
        stall  = (word.op == igdng_pkg::OP_FINISH) && i_stat.out_stall;
        o_ctrl = (r_busy && !stall) ? word : igdng_pkg::CW_IDLE;
    end

    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (!r_busy) begin
            if (i_stat.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end else if (word.op == igdng_pkg::OP_FINISH) begin
            // hold on the last step until the output register frees up
            if (!i_stat.out_stall) begin
                r_busy <= 1'b0;
            end
        end else if (word.jmp == igdng_pkg::JMP_GATE_OFF && i_stat.gate_off) begin
            r_step <= word.target;
        end else begin
            r_step <= r_step + 1'b1;
        end
    end

endmodule

>>> hdl/input_gain_dc_block_noise_gate.sv
// Input front end: gain smoothing, DC blocker, envelope noise gate and input meters.
// Depends on igdng_pkg and igdng_seq (microcode sequencer driving this datapath).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in) carries one Q1.23 sample with
//   its Q4.20 gain target and the clear_meters / last_in_block flags. Each request yields
//   exactly one result on the output channel (o_out_valid / i_out_ready, payload o_out):
//   gated sample, gate state, peak meter and the two energy meters.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so
//   only while idle, which the block does not enforce. Indexes past the last register are
//   ignored, coefficients above 1.0 are clipped to 1.0. The microprogram runs 24 steps
//   with the gate enabled and 14 with a zero threshold. A new request is taken once the
//   sequencer has left its last step and gone idle, never while a sample is in progress.
//   The step count is set by the single shared 27x25 multiplier: every product goes through
//   operand load, multiply and round/store steps of the program.
//   The result sits in an output register; the next request is accepted while it waits.
//   If the receiver still stalls when the next result is due, the sequencer holds on its
//   last step until the register is taken.
//   Reset (synchronous, active low) clears all filter, gate and meter state, restores the
//   register defaults and empties the output register; o_in_ready is low during reset.
module input_gain_dc_block_noise_gate (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  igdng_pkg::t_in               i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output igdng_pkg::t_out              o_out,
    input  logic                         i_cfg_we,
    input  logic [igdng_pkg::CFG_W-1:0]  i_cfg_idx,
    input  logic [igdng_pkg::CW-1:0]     i_cfg_data
);

    localparam int SW    = igdng_pkg::SW;
    localparam int XW    = igdng_pkg::XW;
    localparam int DW    = igdng_pkg::DW;
    localparam int CW    = igdng_pkg::CW;
    localparam int BW    = igdng_pkg::BW;
    localparam int PW    = igdng_pkg::PW;
    localparam int MW    = igdng_pkg::MW;
    localparam int VW    = igdng_pkg::VW;
    localparam int YW    = igdng_pkg::YW;
    localparam int EW    = igdng_pkg::EW;
    localparam int ESW   = igdng_pkg::ESW;
    localparam int THR_W = igdng_pkg::THR_W;

    // Configuration
    logic [THR_W-1:0]      r_gate_thr;
    logic [CW-1:0]         r_dc_coef, r_bright_coef, r_envrel_coef, r_att_coef, r_rel_coef;

    // Block state
    logic [SW-1:0]         r_sg;
    logic signed [SW-1:0]  r_bpi;
    logic signed [XW-1:0]  r_bpo, r_dpi, r_dpo;
    logic [SW-1:0]         r_env;
    logic                  r_det;
    logic [SW-1:0]         r_gg;
    logic [EW-1:0]         r_eacc, r_hacc;
    logic [THR_W-1:0]      r_peak, r_bpeak;
    logic                  r_out_valid;

    // Datapath registers
    igdng_pkg::t_in        r_in;
    logic [DW-1:0]         r_opa;
    logic [BW-1:0]         r_opb;
    logic                  r_neg;
    logic [PW-1:0]         r_prod;
    logic                  r_pneg;
    logic signed [XW-1:0]  r_x;
    logic [SW-1:0]         r_av;
    logic [SW-1:0]         r_g2;
    logic signed [YW-1:0]  r_y;
    igdng_pkg::t_out       r_out;

    igdng_pkg::t_ctrl      ctrl;
    igdng_pkg::t_seq_in    seq_stat;
    logic                  busy;
    logic                  in_acc;

    logic [SW-1:0]         raw_mag;
    logic [XW-1:0]         bh_mag, dy_mag, x_mag;
    logic [SW-1:0]         gate_tgt;
    logic signed [DW-1:0]  p_diff;
    logic [DW-1:0]         diff_mag, p_a;
    logic [BW-1:0]         p_b;
    logic                  p_use_diff, p_neg, p_load;

    logic [MW-1:0]         m24n, m24c, m20n, m23n;
    logic signed [VW-1:0]  v24n, v24c, v20n, v23n;
    logic [ESW-1:0]        acc_sum;
    logic [EW-1:0]         acc_new;
    logic [THR_W-1:0]      pk, peak_fin;
    logic [SW-1:0]         av;
    logic                  det_next;
    logic signed [XW-1:0]  dy_new;

    function automatic logic signed [VW-1:0] apply_sign(input logic [MW-1:0] m,
                                                        input logic neg);
        apply_sign = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    assign in_acc              = i_in_valid && o_in_ready;
    assign o_in_ready          = i_rst_n && !busy;
    assign seq_stat.start      = in_acc;
    assign seq_stat.gate_off   = (r_gate_thr == '0);
    assign seq_stat.out_stall  = r_out_valid && !i_out_ready;

    igdng_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (seq_stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_thr    <= '0;
            r_dc_coef     <= igdng_pkg::DC_COEF_RST;
            r_bright_coef <= igdng_pkg::BRIGHT_COEF_RST;
            r_envrel_coef <= igdng_pkg::ENVREL_COEF_RST;
            r_att_coef    <= igdng_pkg::ATT_COEF_RST;
            r_rel_coef    <= igdng_pkg::REL_COEF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                igdng_pkg::CFG_GATE_THR:    r_gate_thr    <= i_cfg_data[THR_W-1:0];
                igdng_pkg::CFG_DC_COEF:     r_dc_coef     <= igdng_pkg::coef_in(i_cfg_data);
                igdng_pkg::CFG_BRIGHT_COEF: r_bright_coef <= igdng_pkg::coef_in(i_cfg_data);
                igdng_pkg::CFG_ENVREL_COEF: r_envrel_coef <= igdng_pkg::coef_in(i_cfg_data);
                igdng_pkg::CFG_ATT_COEF:    r_att_coef    <= igdng_pkg::coef_in(i_cfg_data);
                igdng_pkg::CFG_REL_COEF:    r_rel_coef    <= igdng_pkg::coef_in(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Operand preparation
    always_comb begin
        raw_mag  = r_in.sample[SW-1] ? SW'(-r_in.sample) : SW'(r_in.sample);
        bh_mag   = r_bpo[XW-1] ? XW'(-r_bpo) : XW'(r_bpo);
        dy_mag   = r_dpo[XW-1] ? XW'(-r_dpo) : XW'(r_dpo);
        x_mag    = r_x[XW-1] ? XW'(-r_x) : XW'(r_x);
        gate_tgt = r_det ? igdng_pkg::GATE_ONE : '0;

        p_diff     = '0;
        p_use_diff = 1'b0;
        p_a        = '0;
        p_b        = '0;
        p_neg      = 1'b0;
        p_load     = 1'b1;
        case (ctrl.prep)
            igdng_pkg::PREP_GAIN: begin
                p_diff     = $signed(DW'(r_in.gain_target)) - $signed(DW'(r_sg));
                p_use_diff = 1'b1;
                p_b        = BW'(igdng_pkg::K_GAIN_STEP);
            end
            igdng_pkg::PREP_BRIGHT: begin
                p_diff     = DW'(r_bpo) + DW'(r_in.sample) - DW'(r_bpi);
                p_use_diff = 1'b1;
                p_b        = BW'(r_bright_coef);
            end
            igdng_pkg::PREP_RAWSQ: begin
                p_a = DW'(raw_mag);
                p_b = BW'(raw_mag);
            end
            igdng_pkg::PREP_X: begin
                p_a   = DW'(raw_mag);
                p_b   = BW'(r_sg);
                p_neg = r_in.sample[SW-1];
            end
            igdng_pkg::PREP_BHSQ: begin
                p_a = DW'(bh_mag);
                p_b = BW'(bh_mag);
            end
            igdng_pkg::PREP_DC: begin
                p_diff     = DW'(r_dpo) + DW'(r_x) - DW'(r_dpi);
                p_use_diff = 1'b1;
                p_b        = BW'(r_dc_coef);
            end
            igdng_pkg::PREP_ENV: begin
                p_diff     = $signed(DW'(r_av)) - $signed(DW'(r_env));
                p_use_diff = 1'b1;
                p_b        = BW'((r_av > r_env) ? igdng_pkg::K_ENV_ATTACK : r_envrel_coef);
            end
            igdng_pkg::PREP_GATE: begin
                p_diff     = $signed(DW'(gate_tgt)) - $signed(DW'(r_gg));
                p_use_diff = 1'b1;
                p_b        = BW'((gate_tgt > r_gg) ? r_att_coef : r_rel_coef);
            end
            igdng_pkg::PREP_G2: begin
                p_a = DW'(r_gg);
                p_b = BW'(r_gg);
            end
            igdng_pkg::PREP_Y: begin
                p_a   = DW'(dy_mag);
                p_b   = BW'(r_g2);
                p_neg = r_dpo[XW-1];
            end
            default: p_load = 1'b0;
        endcase
        diff_mag = p_diff[DW-1] ? DW'(-p_diff) : DW'(p_diff);
    end

    // Rounding of the registered product: nearest (ties away) or ceiling, on magnitude
    always_comb begin
        m24n = MW'(r_prod >> igdng_pkg::COEF_BITS) + MW'(r_prod[igdng_pkg::COEF_BITS-1]);
        m24c = MW'(r_prod >> igdng_pkg::COEF_BITS)
             + MW'(|r_prod[igdng_pkg::COEF_BITS-1:0]);
        m20n = MW'(r_prod >> igdng_pkg::GAIN_FRAC) + MW'(r_prod[igdng_pkg::GAIN_FRAC-1]);
        m23n = MW'(r_prod >> igdng_pkg::GATE_FRAC) + MW'(r_prod[igdng_pkg::GATE_FRAC-1]);
        v24n = apply_sign(m24n, r_pneg);
        v24c = apply_sign(m24c, r_pneg);
        v20n = apply_sign(m20n, r_pneg);
        v23n = apply_sign(m23n, r_pneg);
        dy_new = igdng_pkg::sat_x(v24n);

        // one saturating adder serves both energy meters
        acc_sum = {1'b0, (ctrl.wb == igdng_pkg::WB_HACC) ? r_hacc : r_eacc} + ESW'(r_prod);
        acc_new = (acc_sum >= {1'b0, igdng_pkg::ENERGY_MAX}) ? igdng_pkg::ENERGY_MAX
                                                              : acc_sum[EW-1:0];

        pk  = (x_mag > XW'(igdng_pkg::PEAK_MAX)) ? igdng_pkg::PEAK_MAX : x_mag[THR_W-1:0];
        av  = dy_mag[XW-1] ? igdng_pkg::ENV_MAX : dy_mag[SW-1:0];
        // closing point is half the threshold: compare twice the envelope
        det_next = r_det ? ({r_env, 1'b0} > XW'(r_gate_thr)) : (r_env > SW'(r_gate_thr));
        peak_fin = (r_in.last_in_block && r_bpeak > r_peak) ? r_bpeak : r_peak;
    end

    // Block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sg        <= '0;
            r_bpi       <= '0;
            r_bpo       <= '0;
            r_dpi       <= '0;
            r_dpo       <= '0;
            r_env       <= '0;
            r_det       <= 1'b0;
            r_gg        <= '0;
            r_eacc      <= '0;
            r_hacc      <= '0;
            r_peak      <= '0;
            r_bpeak     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc && i_in.clear_meters) begin
                r_peak <= '0;
                r_eacc <= '0;
                r_hacc <= '0;
            end

            case (ctrl.wb)
                igdng_pkg::WB_GAIN:   r_sg <= SW'($signed(VW'(r_sg)) + v24c);
                igdng_pkg::WB_BRIGHT: begin
                    r_bpo <= igdng_pkg::sat_x(v24n);
                    r_bpi <= r_in.sample;
                end
                igdng_pkg::WB_EACC:   r_eacc <= acc_new;
                igdng_pkg::WB_HACC:   r_hacc <= acc_new;
                igdng_pkg::WB_DC: begin
                    r_dpo <= dy_new;
                    r_dpi <= r_x;
                end
                igdng_pkg::WB_ENV:    r_env <= SW'($signed(VW'(r_env)) + v24c);
                igdng_pkg::WB_GATE:   r_gg  <= SW'($signed(VW'(r_gg)) + v24c);
                default: ;
            endcase

            case (ctrl.op)
                igdng_pkg::OP_PEAK: begin
                    if (pk > r_bpeak) begin
                        r_bpeak <= pk;
                    end
                end
                igdng_pkg::OP_DET: r_det <= det_next;
                igdng_pkg::OP_FINISH: begin
                    if (r_in.last_in_block) begin
                        r_peak  <= peak_fin;
                        r_bpeak <= '0;
                    end
                end
                default: ;
            endcase

            if (ctrl.op == igdng_pkg::OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        if (p_load) begin
            r_opa <= p_use_diff ? diff_mag : p_a;
            r_neg <= p_use_diff ? p_diff[DW-1] : p_neg;
            r_opb <= p_b;
        end
        r_prod <= PW'(r_opa) * PW'(r_opb);
        r_pneg <= r_neg;

        case (ctrl.wb)
            igdng_pkg::WB_X:  r_x  <= igdng_pkg::sat_x(v20n);
            igdng_pkg::WB_DC: r_y  <= YW'(dy_new);
            igdng_pkg::WB_G2: r_g2 <= SW'(m23n);
            igdng_pkg::WB_Y:  r_y  <= YW'(v23n);
            default: ;
        endcase

        if (ctrl.op == igdng_pkg::OP_AV) begin
            r_av <= av;
        end
        if (ctrl.op == igdng_pkg::OP_FINISH) begin
            r_out.out_sample  <= igdng_pkg::sat_s(r_y);
            r_out.gate_open   <= r_det;
            r_out.peak_in     <= peak_fin;
            r_out.energy_all  <= r_eacc;
            r_out.energy_high <= r_hacc;
        end
    end

endmodule

>>> hdl/igdng_checker.sv
// Port-level checks for input_gain_dc_block_noise_gate, attached by bind.
// Depends on igdng_pkg for the result payload type.
module igdng_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input igdng_pkg::t_out o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    // one request at a time: the block goes busy after taking one
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request accepted while processing");

    // no result can come out of the cycle right after a request
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // a finished result frees the input side
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result delivered while still busy");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output not emptied by reset");

endmodule

bind input_gain_dc_block_noise_gate igdng_checker u_igdng_checker (.*);
